/* sv/i2cmts_pkg.sv */
// shared types, codes and helpers for the i2c master transfer sequencer
// used by the top level and the front and back parts; depends on nothing
`default_nettype none

package i2cmts_pkg;

    // bus status codes as reported by the bus controller
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ACK   = 3'd2;
    localparam logic [2:0] ST_NACK  = 3'd3;
    localparam logic [2:0] ST_ARB   = 3'd4;
    localparam logic [2:0] ST_STOP  = 3'd5;

    // bus commands issued with each result
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_ADDR  = 3'd3;
    localparam logic [2:0] CMD_TXB   = 3'd4;
    localparam logic [2:0] CMD_RXB   = 3'd5;

    // phase codes on the result port
    localparam logic [1:0] PC_IDLE  = 2'd0;
    localparam logic [1:0] PC_WAIT  = 2'd1;
    localparam logic [1:0] PC_READ  = 2'd2;
    localparam logic [1:0] PC_WRITE = 2'd3;

    localparam int unsigned BYTE_COUNT_W = 16;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_WAIT  = 4'b0010,
        PH_READ  = 4'b0100,
        PH_WRITE = 4'b1000
    } t_phase;

    // classified bus events
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_START = 3'd1,
        EV_ACK   = 3'd2,
        EV_PAUSE = 3'd3,
        EV_ABORT = 3'd4,
        EV_STOP  = 3'd5
    } t_ev;

    typedef struct packed {
        logic       is_submit;
        t_ev        ev;
        logic [6:0] addr;
        logic [7:0] tx;
        logic [7:0] rx;
    } t_req;

    typedef struct packed {
        logic [2:0]              command;
        logic [7:0]              address_byte;
        logic [1:0]              phase;
        logic [BYTE_COUNT_W-1:0] byte_count;
    } t_rsp;

    function automatic logic [1:0] phase_code(input t_phase p);
        logic [1:0] c;
        case (p)
            PH_IDLE:  c = PC_IDLE;
            PH_WAIT:  c = PC_WAIT;
            PH_READ:  c = PC_READ;
            PH_WRITE: c = PC_WRITE;
            default:  c = PC_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/i2c_master_transfer_sequencer.sv */
// top level of the i2c master transfer sequencer
// depends on i2cmts_pkg, i2cmts_front and i2cmts_back
//
// usage: requests come in through a queue-like port: an item is taken at a
// rising edge with push high and full low. action 0 is a submit (address and
// byte counts), action 1 a bus status report. every request yields exactly
// one result, read from a queue-like port: the oldest result sits on the
// o_ ports while empty is low and leaves at an edge with pop high.
// a request taken into the front queue waits at its head until the state
// update in the back part consumes it and writes its result into the
// result queue, from which it is popped. throughput: one request per cycle
// while the result queue has room or is being popped, set by the state
// update in the back part.
// reset: synchronous, active low; returns to idle with all counts at zero
// and both queues empty.
// stall: when pop stays low the two-entry result queue fills, the back part
// stops taking requests, then the two-entry front queue fills and full rises.
// nothing is dropped; full falls again as soon as results drain.
`default_nettype none

module i2c_master_transfer_sequencer #(
    parameter int unsigned ADDRESS_BYTES = 1,
    parameter int unsigned COUNT_WIDTH   = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request side
    input  wire         push,
    output logic        full,
    input  wire         i_action,
    input  wire  [6:0]  i_slave_addr,
    input  wire  [7:0]  i_tx_count,
    input  wire  [7:0]  i_rx_count,
    input  wire  [2:0]  i_bus_status,
    // result side
    output logic        empty,
    input  wire         pop,
    output logic [2:0]  o_command,
    output logic [7:0]  o_address_byte,
    output logic [1:0]  o_phase,
    output logic [15:0] o_byte_count
);

    // classified requests between front and back
    i2cmts_pkg::t_req q_req;
    logic             q_empty;
    logic             q_pop;
    i2cmts_pkg::t_rsp rsp;

    // front: decode status codes into events, buffer two requests
    i2cmts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_slave_addr (i_slave_addr),
        .i_tx_count   (i_tx_count),
        .i_rx_count   (i_rx_count),
        .i_bus_status (i_bus_status),
        .i_pop        (q_pop),
        .o_empty      (q_empty),
        .o_req        (q_req)
    );

    // back: phase machine, saturating counters and result buffering
    i2cmts_back #(
        .ADDRESS_BYTES (ADDRESS_BYTES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (~q_empty),
        .i_req       (q_req),
        .o_req_pop   (q_pop),
        .i_rsp_pop   (pop & ~empty),
        .o_rsp_empty (empty),
        .o_rsp       (rsp)
    );

    assign o_command      = rsp.command;
    assign o_address_byte = rsp.address_byte;
    assign o_phase        = rsp.phase;
    assign o_byte_count   = rsp.byte_count;

endmodule

`default_nettype wire

/* sv/i2cmts_fifo.sv */
// two-entry queue used between the front and back and on the result side
// depends on nothing; element type is a parameter
`default_nettype none

module i2cmts_fifo #(
    parameter type T = logic [7:0]
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  wire T i_data,
    output logic  o_full,
    input  wire   i_pop,
    output logic  o_empty,
    output T      o_data
);

    T           r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* sv/i2cmts_front.sv */
// front part: classifies incoming requests and queues them for the back part
// depends on i2cmts_pkg and i2cmts_fifo
`default_nettype none

module i2cmts_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    output logic             o_full,
    input  wire              i_action,
    input  wire  [6:0]       i_slave_addr,
    input  wire  [7:0]       i_tx_count,
    input  wire  [7:0]       i_rx_count,
    input  wire  [2:0]       i_bus_status,
    input  wire              i_pop,
    output logic             o_empty,
    output i2cmts_pkg::t_req o_req
);

    i2cmts_pkg::t_req req;
    logic             full;

    always_comb begin
        req.is_submit = ~i_action;
        req.addr      = i_slave_addr;
        req.tx        = i_tx_count;
        req.rx        = i_rx_count;
        req.ev        = i2cmts_pkg::EV_NONE;
        if (i_action) begin
            case (i_bus_status) inside
                i2cmts_pkg::ST_START:                  req.ev = i2cmts_pkg::EV_START;
                i2cmts_pkg::ST_STOP:                   req.ev = i2cmts_pkg::EV_STOP;
                i2cmts_pkg::ST_NACK, i2cmts_pkg::ST_ARB: req.ev = i2cmts_pkg::EV_ABORT;
                i2cmts_pkg::ST_ACK:                    req.ev = i2cmts_pkg::EV_ACK;
                default:                               req.ev = i2cmts_pkg::EV_NONE;
            endcase
        end
    end

    i2cmts_fifo #(
        .T (i2cmts_pkg::t_req)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push & ~full),
        .i_data  (req),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_req)
    );

    assign o_full = full;

endmodule

`default_nettype wire

/* sv/i2cmts_back.sv */
// back part: transaction state, command generation and the result queue
// depends on i2cmts_pkg and i2cmts_fifo
`default_nettype none

module i2cmts_back #(
    parameter int unsigned ADDRESS_BYTES = 1,
    parameter int unsigned COUNT_WIDTH   = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    input  wire i2cmts_pkg::t_req i_req,
    output logic                  o_req_pop,
    input  wire                   i_rsp_pop,
    output logic                  o_rsp_empty,
    output i2cmts_pkg::t_rsp      o_rsp
);

    localparam int unsigned CW = COUNT_WIDTH;
    localparam logic [CW-1:0] AB = CW'(ADDRESS_BYTES);

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    i2cmts_pkg::t_phase r_phase, n_phase;
    logic [6:0]         r_addr, n_addr;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_limit, n_limit;
    logic [CW-1:0]      r_tx, n_tx;
    logic [CW-1:0]      r_rx, n_rx;
    logic               r_dir_tx, n_dir_tx;

    i2cmts_pkg::t_ev    ev;
    i2cmts_pkg::t_phase ep;
    logic               enter;
    logic [2:0]         cmd;
    logic [7:0]         addr_byte;
    i2cmts_pkg::t_rsp   rsp;
    logic               rsp_full;
    logic               take;

    assign take      = i_req_valid & (~rsp_full | i_rsp_pop);
    assign o_req_pop = take;

    always_comb begin
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_count   = r_count;
        n_limit   = r_limit;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_dir_tx  = r_dir_tx;
        ev        = i_req.ev;
        ep        = r_phase;
        enter     = 1'b0;
        cmd       = i2cmts_pkg::CMD_NONE;
        addr_byte = 8'd0;

        if (i_req.is_submit) begin
            n_addr = i_req.addr;
            case (r_phase)
                i2cmts_pkg::PH_IDLE: begin
                    n_count = '0;
                    n_tx    = sat_add(CW'(i_req.tx), AB);
                    n_rx    = CW'(i_req.rx);
                    if (n_tx != '0) begin
                        n_limit  = n_tx;
                        n_dir_tx = 1'b1;
                    end else if (n_rx != '0) begin
                        n_limit  = n_rx;
                        n_dir_tx = 1'b0;
                    end
                    enter = 1'b1;
                    ep    = i2cmts_pkg::PH_WAIT;
                end
                i2cmts_pkg::PH_WRITE: begin
                    n_tx    = sat_add(r_tx, CW'(i_req.tx));
                    n_limit = sat_add(r_limit, CW'(i_req.tx));
                    n_rx    = sat_add(r_rx, CW'(i_req.rx));
                end
                i2cmts_pkg::PH_READ: begin
                    n_rx    = sat_add(r_rx, CW'(i_req.rx));
                    n_limit = sat_add(r_limit, CW'(i_req.rx));
                end
                default: begin
                end
            endcase
        end else begin
            // ack bumps the count in any phase, then resolves to pause or stop
            if (i_req.ev == i2cmts_pkg::EV_ACK) begin
                n_count = sat_add(r_count, CW'(1));
                ev = (n_count == r_limit) ? i2cmts_pkg::EV_STOP : i2cmts_pkg::EV_PAUSE;
            end
            case (r_phase)
                i2cmts_pkg::PH_READ: begin
                    if (ev == i2cmts_pkg::EV_PAUSE) begin
                        enter = 1'b1;
                        ep    = i2cmts_pkg::PH_READ;
                    end else if (ev == i2cmts_pkg::EV_ABORT || ev == i2cmts_pkg::EV_STOP) begin
                        enter = 1'b1;
                        ep    = i2cmts_pkg::PH_IDLE;
                    end
                end
                i2cmts_pkg::PH_WRITE: begin
                    if (ev == i2cmts_pkg::EV_PAUSE) begin
                        enter = 1'b1;
                        ep    = i2cmts_pkg::PH_WRITE;
                    end else if (ev == i2cmts_pkg::EV_ABORT) begin
                        enter = 1'b1;
                        ep    = i2cmts_pkg::PH_IDLE;
                    end else if (ev == i2cmts_pkg::EV_STOP) begin
                        enter = 1'b1;
                        if (r_rx != '0) begin
                            n_count  = '0;
                            n_limit  = r_rx;
                            n_dir_tx = 1'b0;
                            ep       = i2cmts_pkg::PH_READ;
                        end else begin
                            ep = i2cmts_pkg::PH_IDLE;
                        end
                    end
                end
                i2cmts_pkg::PH_WAIT: begin
                    if (ev == i2cmts_pkg::EV_START) begin
                        enter = 1'b1;
                        ep    = r_dir_tx ? i2cmts_pkg::PH_WRITE : i2cmts_pkg::PH_READ;
                    end
                end
                default: begin
                end
            endcase
        end

        // command for the phase being entered
        if (enter) begin
            n_phase = ep;
            case (ep)
                i2cmts_pkg::PH_IDLE: begin
                    if (n_rx == '0) begin
                        cmd = i2cmts_pkg::CMD_STOP;
                    end
                end
                i2cmts_pkg::PH_WAIT: begin
                    cmd = i2cmts_pkg::CMD_START;
                end
                i2cmts_pkg::PH_WRITE: begin
                    if (n_count < AB) begin
                        cmd       = i2cmts_pkg::CMD_ADDR;
                        addr_byte = {n_addr, (n_tx <= AB)};
                    end else if (n_count < n_limit) begin
                        cmd = i2cmts_pkg::CMD_TXB;
                    end
                end
                i2cmts_pkg::PH_READ: begin
                    if (n_count < n_limit) begin
                        cmd = i2cmts_pkg::CMD_RXB;
                    end
                end
                default: begin
                end
            endcase
        end

        rsp.command      = cmd;
        rsp.address_byte = addr_byte;
        rsp.phase        = i2cmts_pkg::phase_code(n_phase);
        rsp.byte_count   = i2cmts_pkg::BYTE_COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= i2cmts_pkg::PH_IDLE;
            r_addr   <= 7'd0;
            r_count  <= '0;
            r_limit  <= '0;
            r_tx     <= '0;
            r_rx     <= '0;
            r_dir_tx <= 1'b0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_addr   <= n_addr;
            r_count  <= n_count;
            r_limit  <= n_limit;
            r_tx     <= n_tx;
            r_rx     <= n_rx;
            r_dir_tx <= n_dir_tx;
        end
    end

    i2cmts_fifo #(
        .T (i2cmts_pkg::t_rsp)
    ) u_rsp_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (rsp),
        .o_full  (rsp_full),
        .i_pop   (i_rsp_pop),
        .o_empty (o_rsp_empty),
        .o_data  (o_rsp)
    );

endmodule

`default_nettype wire

/* tb/sv/i2c_master_transfer_sequencer_test.sv */
// self-checking testbench for the i2c master transfer sequencer
// depends on i2cmts_pkg and i2c_master_transfer_sequencer
`default_nettype none

module i2c_master_transfer_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    // status codes 6 and 7 carry no event
    localparam logic [2:0]  ST_SPARE_LO = 3'd6;
    localparam logic [2:0]  ST_SPARE_HI = 3'd7;
    localparam logic [15:0] ADDR_BYTES  = 16'd1;
    // last requests of the run go through with no idling on either side
    localparam int unsigned CALM_TAIL   = 200;

    typedef struct packed {
        logic       action;
        logic [6:0] addr;
        logic [7:0] tx;
        logic [7:0] rx;
        logic [2:0] status;
    } t_xfer_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_action = 1'b0;
    logic [6:0]  i_slave_addr = 7'd0;
    logic [7:0]  i_tx_count = 8'd0;
    logic [7:0]  i_rx_count = 8'd0;
    logic [2:0]  i_bus_status = 3'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_command;
    logic [7:0]  o_address_byte;
    logic [1:0]  o_phase;
    logic [15:0] o_byte_count;

    i2c_master_transfer_sequencer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_slave_addr   (i_slave_addr),
        .i_tx_count     (i_tx_count),
        .i_rx_count     (i_rx_count),
        .i_bus_status   (i_bus_status),
        .empty          (empty),
        .pop            (pop),
        .o_command      (o_command),
        .o_address_byte (o_address_byte),
        .o_phase        (o_phase),
        .o_byte_count   (o_byte_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // requests waiting to be driven, and the bus commands they should produce
    t_xfer_req          req_q[$];
    i2cmts_pkg::t_rsp   bus_cmd_q[$];
    int unsigned        n_queued = 0;
    int unsigned        n_bad = 0;

    // sequencer state as the checker sees it
    logic [1:0]  ph = i2cmts_pkg::PC_IDLE;
    logic [6:0]  addr_q = 7'd0;
    logic [15:0] done_cnt = 16'd0;
    logic [15:0] limit_cnt = 16'd0;
    logic [15:0] tx_sum = 16'd0;
    logic [15:0] rx_sum = 16'd0;
    logic        to_slave = 1'b0;
    logic [2:0]  cmd_x;
    logic [7:0]  abyte_x;

    // idle burst state for both sides
    int unsigned push_burst = 0;
    int unsigned push_quiet = 0;
    int unsigned pop_burst = 0;
    int unsigned pop_quiet = 0;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // switch phase and pick the bus command issued on entry
    function automatic void move_to(input logic [1:0] p);
        ph = p;
        cmd_x = i2cmts_pkg::CMD_NONE;
        abyte_x = 8'h00;
        case (p)
            i2cmts_pkg::PC_IDLE: if (rx_sum == 16'd0) cmd_x = i2cmts_pkg::CMD_STOP;
            i2cmts_pkg::PC_WAIT: cmd_x = i2cmts_pkg::CMD_START;
            i2cmts_pkg::PC_WRITE: begin
                if (done_cnt < ADDR_BYTES) begin
                    // read bit set when no data byte follows the address
                    cmd_x = i2cmts_pkg::CMD_ADDR;
                    abyte_x = {addr_q, (tx_sum <= ADDR_BYTES) ? 1'b1 : 1'b0};
                end else if (done_cnt < limit_cnt) begin
                    cmd_x = i2cmts_pkg::CMD_TXB;
                end
            end
            default: if (done_cnt < limit_cnt) cmd_x = i2cmts_pkg::CMD_RXB;
        endcase
    endfunction

    // apply one request to the checker state, return the expected bus command
    function automatic i2cmts_pkg::t_rsp predict_bus_command(input t_xfer_req r);
        i2cmts_pkg::t_rsp res;
        i2cmts_pkg::t_ev  ev;
        cmd_x = i2cmts_pkg::CMD_NONE;
        abyte_x = 8'h00;
        ev = i2cmts_pkg::EV_NONE;
        if (!r.action) begin
            addr_q = r.addr;
            case (ph)
                i2cmts_pkg::PC_IDLE: begin
                    done_cnt = 16'd0;
                    tx_sum = sat_add16({8'd0, r.tx}, ADDR_BYTES);
                    rx_sum = {8'd0, r.rx};
                    if (tx_sum != 16'd0) begin
                        limit_cnt = tx_sum;
                        to_slave = 1'b1;
                    end else if (rx_sum != 16'd0) begin
                        limit_cnt = rx_sum;
                        to_slave = 1'b0;
                    end
                    move_to(i2cmts_pkg::PC_WAIT);
                end
                i2cmts_pkg::PC_WRITE: begin
                    tx_sum = sat_add16(tx_sum, {8'd0, r.tx});
                    limit_cnt = sat_add16(limit_cnt, {8'd0, r.tx});
                    rx_sum = sat_add16(rx_sum, {8'd0, r.rx});
                end
                i2cmts_pkg::PC_READ: begin
                    rx_sum = sat_add16(rx_sum, {8'd0, r.rx});
                    limit_cnt = sat_add16(limit_cnt, {8'd0, r.rx});
                end
                default: ;
            endcase
        end else begin
            case (r.status)
                i2cmts_pkg::ST_START: ev = i2cmts_pkg::EV_START;
                i2cmts_pkg::ST_STOP: ev = i2cmts_pkg::EV_STOP;
                i2cmts_pkg::ST_NACK, i2cmts_pkg::ST_ARB: ev = i2cmts_pkg::EV_ABORT;
                i2cmts_pkg::ST_ACK: begin
                    // the count moves on in every phase
                    done_cnt = sat_add16(done_cnt, 16'd1);
                    ev = (done_cnt == limit_cnt) ? i2cmts_pkg::EV_STOP : i2cmts_pkg::EV_PAUSE;
                end
                default: ev = i2cmts_pkg::EV_NONE;
            endcase
            case (ph)
                i2cmts_pkg::PC_READ: begin
                    if (ev == i2cmts_pkg::EV_PAUSE) begin
                        move_to(i2cmts_pkg::PC_READ);
                    end else if (ev == i2cmts_pkg::EV_ABORT || ev == i2cmts_pkg::EV_STOP) begin
                        move_to(i2cmts_pkg::PC_IDLE);
                    end
                end
                i2cmts_pkg::PC_WRITE: begin
                    if (ev == i2cmts_pkg::EV_PAUSE) begin
                        move_to(i2cmts_pkg::PC_WRITE);
                    end else if (ev == i2cmts_pkg::EV_ABORT) begin
                        move_to(i2cmts_pkg::PC_IDLE);
                    end else if (ev == i2cmts_pkg::EV_STOP) begin
                        // write done: turn around when receive bytes are pending
                        if (rx_sum != 16'd0) begin
                            done_cnt = 16'd0;
                            limit_cnt = rx_sum;
                            to_slave = 1'b0;
                            move_to(i2cmts_pkg::PC_READ);
                        end else begin
                            move_to(i2cmts_pkg::PC_IDLE);
                        end
                    end
                end
                i2cmts_pkg::PC_WAIT: begin
                    if (ev == i2cmts_pkg::EV_START) begin
                        move_to(to_slave ? i2cmts_pkg::PC_WRITE : i2cmts_pkg::PC_READ);
                    end
                end
                default: ;
            endcase
        end
        res.command = cmd_x;
        res.address_byte = (cmd_x == i2cmts_pkg::CMD_ADDR) ? abyte_x : 8'h00;
        res.phase = ph;
        res.byte_count = done_cnt;
        return res;
    endfunction

    // random idle bursts with quiet stretches in between; none near the end
    function automatic bit take_break(inout int unsigned burst, inout int unsigned quiet);
        if (req_q.size() < CALM_TAIL) return 1'b0;
        if (burst != 0) begin
            burst = burst - 1;
            return 1'b1;
        end
        if (quiet != 0) begin
            quiet = quiet - 1;
            return 1'b0;
        end
        case ($urandom_range(0, 39))
            0: quiet = $urandom_range(30, 200);
            1, 2, 3, 4, 5, 6: begin
                burst = $urandom_range(0, 7);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void add_item(input logic act, input logic [6:0] a,
                                     input logic [7:0] tx, input logic [7:0] rx,
                                     input logic [2:0] st);
        t_xfer_req r;
        r.action = act;
        r.addr = a;
        r.tx = tx;
        r.rx = rx;
        r.status = st;
        req_q.push_back(r);
        n_queued = n_queued + 1;
    endfunction

    // unused fields get random values so every input bit toggles
    function automatic void add_submit(input logic [6:0] a, input logic [7:0] tx,
                                       input logic [7:0] rx);
        add_item(1'b0, a, tx, rx, 3'($urandom_range(0, 7)));
    endfunction

    function automatic void add_status(input logic [2:0] st);
        add_item(1'b1, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), st);
    endfunction

    function automatic void add_noise();
        add_item(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 3'($urandom_range(0, 7)));
    endfunction

    // one write-then-read transfer with random lengths, extensions, aborts and noise
    function automatic void add_random_transfer();
        int unsigned tx_left;
        int unsigned rx_left;
        int unsigned ext_tx;
        int unsigned ext_rx;
        tx_left = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        if ($urandom_range(0, 2) == 0) rx_left = 0;
        else if ($urandom_range(0, 15) == 0) rx_left = $urandom_range(1, 255);
        else rx_left = $urandom_range(1, 6);
        add_submit(7'($urandom_range(0, 127)), 8'(tx_left), 8'(rx_left));
        if ($urandom_range(0, 7) == 0) add_noise();
        add_status(i2cmts_pkg::ST_START);
        tx_left = tx_left + 1;   // address byte first
        while (tx_left != 0) begin
            case ($urandom_range(0, 59))
                0: begin
                    add_status($urandom_range(0, 1) ? i2cmts_pkg::ST_NACK : i2cmts_pkg::ST_ARB);
                    return;
                end
                1: add_noise();
                2: begin
                    ext_tx = $urandom_range(0, 3);
                    ext_rx = $urandom_range(0, 3);
                    add_submit(7'($urandom_range(0, 127)), 8'(ext_tx), 8'(ext_rx));
                    tx_left = tx_left + ext_tx;
                    rx_left = rx_left + ext_rx;
                end
                default: begin
                    add_status(i2cmts_pkg::ST_ACK);
                    tx_left = tx_left - 1;
                end
            endcase
        end
        while (rx_left != 0) begin
            case ($urandom_range(0, 59))
                0: begin
                    add_status($urandom_range(0, 1) ? i2cmts_pkg::ST_NACK : i2cmts_pkg::ST_ARB);
                    return;
                end
                1: add_noise();
                2: begin
                    ext_rx = $urandom_range(0, 3);
                    add_submit(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                               8'(ext_rx));
                    rx_left = rx_left + ext_rx;
                end
                default: begin
                    add_status(i2cmts_pkg::ST_ACK);
                    rx_left = rx_left - 1;
                end
            endcase
        end
        // sometimes a stray pair of stops to shake loose a lost sequence
        if ($urandom_range(0, 3) == 0) begin
            add_status(i2cmts_pkg::ST_STOP);
            add_status(i2cmts_pkg::ST_STOP);
        end
    endfunction

    function automatic void flag_bus_error(input string why, input i2cmts_pkg::t_rsp want,
                                           input i2cmts_pkg::t_rsp got);
        n_bad = n_bad + 1;
        if (n_bad <= 10) begin
            $display("%0t: %s", $realtime, why);
            $display("  expected cmd=%0d addr=%02h phase=%0d count=%0d",
                     want.command, want.address_byte, want.phase, want.byte_count);
            $display("  actual   cmd=%0d addr=%02h phase=%0d count=%0d",
                     got.command, got.address_byte, got.phase, got.byte_count);
        end
    endfunction

    // request side: take note of accepted requests at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            bus_cmd_q.push_back(predict_bus_command(req_q[0]));
            void'(req_q.pop_front());
        end
    end

    // request side: present the next request at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n || req_q.size() == 0 || take_break(push_burst, push_quiet)) begin
            push <= 1'b0;
        end else begin
            push <= 1'b1;
            i_action <= req_q[0].action;
            i_slave_addr <= req_q[0].addr;
            i_tx_count <= req_q[0].tx;
            i_rx_count <= req_q[0].rx;
            i_bus_status <= req_q[0].status;
        end
    end

    // result side: compare each popped result with the oldest expectation
    always @(posedge i_clk) begin : bus_cmd_check
        i2cmts_pkg::t_rsp got;
        i2cmts_pkg::t_rsp want;
        if (i_rst_n && pop && !empty) begin
            got = {o_command, o_address_byte, o_phase, o_byte_count};
            if (bus_cmd_q.size() == 0) begin
                flag_bus_error("result with no pending request", '0, got);
            end else begin
                want = bus_cmd_q.pop_front();
                if (got !== want) flag_bus_error("result mismatch", want, got);
            end
        end
    end

    // result side: pop with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= !take_break(pop_burst, pop_quiet);
    end

    initial begin
        int unsigned mark;

        // idle: an ack still counts, other events do nothing
        add_status(i2cmts_pkg::ST_ACK);
        add_status(i2cmts_pkg::ST_STOP);
        add_status(i2cmts_pkg::ST_NACK);
        add_status(ST_SPARE_LO);
        add_status(ST_SPARE_HI);
        // zero-length write: start, then ack and address change while waiting
        add_submit(7'h7F, 8'h00, 8'h00);
        add_status(i2cmts_pkg::ST_ACK);
        add_submit(7'h00, 8'hFF, 8'hFF);
        // count already at the limit: write entered with no command
        add_status(i2cmts_pkg::ST_START);
        add_status(i2cmts_pkg::ST_ACK);
        add_status(i2cmts_pkg::ST_ARB);
        // full-size request, extended in write, early stop turns to read
        add_submit(7'h7F, 8'hFF, 8'hFF);
        add_status(i2cmts_pkg::ST_START);
        add_status(i2cmts_pkg::ST_ACK);
        add_submit(7'h55, 8'hFF, 8'h00);
        add_status(i2cmts_pkg::ST_STOP);
        add_status(i2cmts_pkg::ST_ACK);
        add_submit(7'h2A, 8'h00, 8'hFF);
        add_status(i2cmts_pkg::ST_IDLE);
        // abort with receive bytes pending: no stop condition
        add_status(i2cmts_pkg::ST_NACK);
        // address only, then one byte read
        add_submit(7'h2A, 8'h00, 8'h01);
        add_status(i2cmts_pkg::ST_START);
        add_status(i2cmts_pkg::ST_ACK);
        add_status(i2cmts_pkg::ST_ACK);
        add_status(i2cmts_pkg::ST_START);

        while (n_queued < 1180) add_random_transfer();

        // saturate the totals and the limit: force idle, grow them past the
        // top while writing, abort, then a few acks while idle
        add_status(i2cmts_pkg::ST_START);
        add_status(i2cmts_pkg::ST_NACK);
        add_submit(7'h3C, 8'hFF, 8'hFF);
        add_status(i2cmts_pkg::ST_START);
        repeat (258) add_submit(7'($urandom_range(0, 127)), 8'hFF, 8'hFF);
        add_status(i2cmts_pkg::ST_ARB);
        repeat (6) add_status(i2cmts_pkg::ST_ACK);

        mark = n_queued;
        while (n_queued < mark + CALM_TAIL) add_random_transfer();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0) @(posedge i_clk);
        while (bus_cmd_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_bad == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
